### sv/motor_safety_supervisor_core_macros.svh
// Assertion macros shared by the checker of the motor safety supervisor.
// Depends on nothing; expects clk_i and rst_ni in the scope where it is used.
`ifndef MOTOR_SAFETY_SUPERVISOR_CORE_MACROS_SVH
`define MOTOR_SAFETY_SUPERVISOR_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MSUP_ASSERT_IMPL(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MSUP_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

### sv/msup_pkg.sv
// Types, codes and defaults for the motor safety supervisor.
// No dependencies; imported by every module of the block.
package msup_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int STAMP_WIDTH_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int LIMIT_W    = 8;
  localparam int TILT_W     = 15;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_UNLOCK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_PROT_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT    = 3'd5;

  // IMU status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_ACC_BLUNT   = 3'd1;
  localparam logic [2:0] ST_ACC_OVER    = 3'd2;
  localparam logic [2:0] ST_GYRO_BLUNT  = 3'd3;
  localparam logic [2:0] ST_GYRO_OVER   = 3'd4;
  localparam logic [2:0] ST_UNREADY     = 3'd5;
  localparam logic [2:0] ST_OVER_ACCEL  = 3'd6;

  typedef enum logic [1:0] {
    MODE_LOCKED   = 2'd0,
    MODE_UNLOCKED = 2'd1,
    MODE_TILT_ERR = 2'd2
  } mode_e;

  typedef struct packed {
    logic               free_unlock;
    logic               rate_protect_enable;
    logic [LIMIT_W-1:0] stale_limit;
    logic [LIMIT_W-1:0] silent_limit;
    logic [LIMIT_W-1:0] warning_limit;
    logic [TILT_W-1:0]  tilt_limit;
  } cfg_t;

  typedef struct packed {
    logic               lock_request;
    logic               sample_valid;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic [31:0]        imu_stamp;
    logic [2:0]         imu_status;
    logic               upside_down;
    logic               usb_hold;
  } in_item_t;

  typedef struct packed {
    logic       motor_drive;
    logic       sensor_abort;
    logic       reuse_last_sample;
    logic [1:0] unlock_mode_out;
    logic       rate_protect_out;
  } out_item_t;

endpackage

### sv/msup_cfg.sv
// Configuration register file of the motor safety supervisor.
// Depends on msup_pkg.
module msup_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msup_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output msup_pkg::cfg_t                   cfg_o
);
  import msup_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FREE_UNLOCK:   cfg_d.free_unlock         = cfg_wdata_i[0];
        CFG_RATE_PROT_EN:  cfg_d.rate_protect_enable = cfg_wdata_i[0];
        CFG_STALE_LIMIT:   cfg_d.stale_limit         = cfg_wdata_i[LIMIT_W-1:0];
        CFG_SILENT_LIMIT:  cfg_d.silent_limit        = cfg_wdata_i[LIMIT_W-1:0];
        CFG_WARNING_LIMIT: cfg_d.warning_limit       = cfg_wdata_i[LIMIT_W-1:0];
        CFG_TILT_LIMIT:    cfg_d.tilt_limit          = cfg_wdata_i[TILT_W-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.free_unlock         <= 1'b0;
      cfg_q.rate_protect_enable <= 1'b1;
      cfg_q.stale_limit         <= 8'd10;
      cfg_q.silent_limit        <= 8'd10;
      cfg_q.warning_limit       <= 8'd5;
      cfg_q.tilt_limit          <= 15'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/msup_tick.sv
// Per-tick decision logic and supervisor state (unlock mode, watchdog, latch).
// Depends on msup_pkg; state advances only when the top level fires a beat.
module msup_tick #(
  parameter int COUNT_WIDTH = msup_pkg::COUNT_WIDTH_DEF,
  parameter int STAMP_WIDTH = msup_pkg::STAMP_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  msup_pkg::cfg_t        cfg_i,
  input  msup_pkg::in_item_t    item_i,
  output msup_pkg::out_item_t   res_o
);
  import msup_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  mode_e                  mode_q, mode_d;
  logic [STAMP_WIDTH-1:0] last_q, last_d;
  logic [COUNT_WIDTH-1:0] stale_q, stale_d;
  logic [COUNT_WIDTH-1:0] silent_q, silent_d;
  logic [COUNT_WIDTH-1:0] warn_q, warn_d;
  logic                   latch_q, latch_d;

  logic [STAMP_WIDTH-1:0] stamp;
  logic                   tilt_ok;
  logic                   run;
  logic                   drive;
  logic                   abort_f;
  logic                   reuse_f;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] c,
                                   input logic [LIMIT_W-1:0] lim);
    return CMP_W'(c) >= CMP_W'(lim);
  endfunction

  function automatic logic angle_in_band(input logic signed [15:0] a,
                                         input logic [TILT_W-1:0] lim);
    logic signed [16:0] a_x;
    logic signed [16:0] lim_x;
    a_x   = 17'(a);
    lim_x = $signed({2'b00, lim});
    return (a_x <= lim_x) && (a_x >= -lim_x);
  endfunction

  assign stamp   = item_i.imu_stamp[STAMP_WIDTH-1:0];
  assign tilt_ok = angle_in_band(item_i.pitch_angle, cfg_i.tilt_limit) &&
                   angle_in_band(item_i.roll_angle, cfg_i.tilt_limit);

  always_comb begin
    mode_d   = mode_q;
    last_d   = last_q;
    stale_d  = stale_q;
    silent_d = silent_q;
    warn_d   = warn_q;
    latch_d  = latch_q;
    run      = 1'b1;
    drive    = 1'b0;
    abort_f  = 1'b0;
    reuse_f  = 1'b0;
    if (item_i.sample_valid) begin
      if (item_i.lock_request) begin
        mode_d = MODE_LOCKED;
      end else if (cfg_i.free_unlock) begin
        mode_d = MODE_UNLOCKED;
      end else if (mode_q != MODE_UNLOCKED && mode_q != MODE_TILT_ERR) begin
        mode_d = tilt_ok ? MODE_UNLOCKED : MODE_TILT_ERR;
      end

      if (mode_d != MODE_UNLOCKED) begin
        run = 1'b0;
      end else if (stamp == '0) begin
        // no update from the IMU this tick
        silent_d = sat_inc(silent_q);
        abort_f  = reached(silent_d, cfg_i.silent_limit);
        run      = 1'b0;
      end else begin
        if (stamp > last_q) begin
          stale_d = '0;
          last_d  = stamp;
        end else begin
          stale_d = sat_inc(stale_q);
          if (reached(stale_d, cfg_i.stale_limit)) begin
            abort_f = 1'b1;
            run     = 1'b0;
          end
        end

        if (run) begin
          case (item_i.imu_status) inside
            ST_OK: silent_d = '0;
            ST_GYRO_BLUNT, ST_GYRO_OVER: begin
              abort_f = 1'b1;
              run     = 1'b0;
            end
            ST_UNREADY: begin
              silent_d = sat_inc(silent_q);
              if (reached(silent_d, cfg_i.silent_limit)) begin
                abort_f = 1'b1;
                run     = 1'b0;
              end else begin
                reuse_f = 1'b1;
              end
            end
            ST_OVER_ACCEL: begin
              if (CMP_W'(warn_q) < CMP_W'(cfg_i.warning_limit)) begin
                warn_d  = sat_inc(warn_q);
                reuse_f = 1'b1;
              end else begin
                latch_d = 1'b1;
              end
            end
            default: ;
          endcase
        end

        if (run) begin
          drive = !(cfg_i.rate_protect_enable && latch_d) &&
                  !item_i.upside_down && !item_i.usb_hold;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_LOCKED;
      last_q   <= '0;
      stale_q  <= '0;
      silent_q <= '0;
      warn_q   <= '0;
      latch_q  <= 1'b0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      last_q   <= last_d;
      stale_q  <= stale_d;
      silent_q <= silent_d;
      warn_q   <= warn_d;
      latch_q  <= latch_d;
    end
  end

  always_comb begin
    res_o.motor_drive       = drive;
    res_o.sensor_abort      = abort_f;
    res_o.reuse_last_sample = reuse_f;
    res_o.unlock_mode_out   = mode_d;
    res_o.rate_protect_out  = latch_d;
  end

endmodule

### sv/motor_safety_supervisor_core.sv
// Channel   Dir  Handshake            Beat
// in        in   in_valid_i/in_stall_o  in_item_i  (one control tick)
// out       out  out_valid_o/out_stall_i out_item_o (one decision)
// cfg       in   cfg_we_i               cfg_idx_i / cfg_wdata_i
//
// Input register, then result register; one tick per cycle sustained unless out_stall_i holds a result.
// The input register feeds the decision logic, which updates state and
// loads the result register in the same cycle.
// Async active-low reset clears valids, config defaults and state; no clear pass.
// While the result register is stalled a held tick waits in the input register.
// Depends on msup_pkg, msup_cfg and msup_tick.
module motor_safety_supervisor_core #(
  parameter int COUNT_WIDTH = msup_pkg::COUNT_WIDTH_DEF,
  parameter int STAMP_WIDTH = msup_pkg::STAMP_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  msup_pkg::in_item_t               in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output msup_pkg::out_item_t              out_item_o,
  input  logic                             cfg_we_i,
  input  logic [msup_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [msup_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import msup_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_item_q;
  out_item_t res;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  logic      fire;
  logic      accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  msup_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  msup_tick #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_tick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cfg_i  (cfg),
    .item_i (in_item_q),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/msup_chk.sv
// Port-level checker for the motor safety supervisor, bound to the top level.
// Depends on msup_pkg and motor_safety_supervisor_core_macros.svh.
`include "motor_safety_supervisor_core_macros.svh"

module msup_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input msup_pkg::out_item_t  out_item_o
);
  import msup_pkg::*;

  // drive only ever comes with the unlocked mode
  `MSUP_ASSERT_IMPL(a_drive_unlocked, out_valid_o && out_item_o.motor_drive,
                    out_item_o.unlock_mode_out == MODE_UNLOCKED, "drive while not unlocked")
  // an aborted tick never drives
  `MSUP_ASSERT_IMPL(a_abort_no_drive, out_valid_o && out_item_o.sensor_abort,
                    !out_item_o.motor_drive, "drive on aborted tick")
  // input side only backs up when the result beat is held
  `MSUP_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                    "input stalled with free output")
  // a held result beat stays put
  `MSUP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_item_o), "stalled result changed")

endmodule

bind motor_safety_supervisor_core msup_chk u_msup_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
